FILE: rtl/slt_pkg.sv
// ----------------------------------------------------------------------------
// Scanner package
// Token kinds, scan modes, payload structs and keyword lookup for the scanner.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int unsigned KeywordChars = 10;
  localparam int unsigned CountBits    = 16;
  localparam int unsigned OutBits      = 16;

  localparam logic [5:0] KLparen  = 6'd0;
  localparam logic [5:0] KRparen  = 6'd1;
  localparam logic [5:0] KLbrack  = 6'd2;
  localparam logic [5:0] KRbrack  = 6'd3;
  localparam logic [5:0] KLbrace  = 6'd4;
  localparam logic [5:0] KRbrace  = 6'd5;
  localparam logic [5:0] KSemi    = 6'd6;
  localparam logic [5:0] KComma   = 6'd7;
  localparam logic [5:0] KDot     = 6'd8;
  localparam logic [5:0] KMinus   = 6'd9;
  localparam logic [5:0] KPlus    = 6'd10;
  localparam logic [5:0] KSlash   = 6'd11;
  localparam logic [5:0] KStar    = 6'd12;
  localparam logic [5:0] KBang    = 6'd13;
  localparam logic [5:0] KEqual   = 6'd15;
  localparam logic [5:0] KLess    = 6'd17;
  localparam logic [5:0] KGreater = 6'd19;
  localparam logic [5:0] KIdent   = 6'd21;
  localparam logic [5:0] KString  = 6'd22;
  localparam logic [5:0] KInterp  = 6'd23;
  localparam logic [5:0] KNumber  = 6'd24;
  localparam logic [5:0] KKw0     = 6'd25;
  localparam logic [5:0] KError   = 6'd47;
  localparam logic [5:0] KEnd     = 6'd48;

  localparam logic [1:0] ErrNone   = 2'd0;
  localparam logic [1:0] ErrChar   = 2'd1;
  localparam logic [1:0] ErrString = 2'd2;
  localparam logic [1:0] ErrInterp = 2'd3;

  typedef enum logic [3:0] {
    ModeIdle, ModeIdent, ModeNumber, ModeNumDot, ModeFraction,
    ModeOp2, ModeSlash, ModeComment, ModeString, ModeDollar
  } mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_source;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [1:0]  error_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] token_length;
    logic        last;
  } out_beat_t;

  localparam int unsigned NumKw = 22;
  localparam logic [79:0] KwText [NumKw] = '{
    "and", "case", "class", "default", "else", "false", "for", "fun",
    "if", "in", "instanceof", "nil", "nmut", "or", "print", "return",
    "super", "switch", "this", "true", "var", "while"
  };
  localparam logic [3:0] KwLen [NumKw] = '{
    4'd3, 4'd4, 4'd5, 4'd7, 4'd4, 4'd5, 4'd3, 4'd3, 4'd2, 4'd2, 4'd10,
    4'd3, 4'd4, 4'd2, 4'd5, 4'd6, 4'd5, 4'd6, 4'd4, 4'd4, 4'd3, 4'd5
  };

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Match the first ten buffered characters against the keyword list.
  // Text is right-aligned in the literal, so character i sits at byte len-1-i.
  function automatic logic [5:0] kw_kind(logic [79:0] buf_text, logic [3:0] len);
    logic [5:0] k;
    logic       hit;
    k = KIdent;
    for (int i = 0; i < NumKw; i++) begin
      hit = (KwLen[i] == len);
      for (int j = 0; j < 10; j++) begin
        if (j < int'(len) && KwText[i][8*(int'(len)-1-j) +: 8] != buf_text[8*j +: 8])
          hit = 1'b0;
      end
      if (hit) k = KKw0 + 6'(i);
    end
    return k;
  endfunction

endpackage

FILE: rtl/slt_core.sv
// ----------------------------------------------------------------------------
// Scanner core
// Next-state and token logic for one byte or end marker; up to three tokens.
// ----------------------------------------------------------------------------
module slt_core #(
  parameter int unsigned KEYWORD_CHARS = slt_pkg::KeywordChars,
  parameter int unsigned COUNT_BITS    = slt_pkg::CountBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  slt_pkg::in_beat_t         beat_i,
  output slt_pkg::out_beat_t        tok_o [3],
  output logic [1:0]                count_o
);
  localparam logic [COUNT_BITS-1:0] CMax = '1;
  localparam logic [COUNT_BITS-1:0] COne = COUNT_BITS'(1);
  localparam int unsigned IdxW = $clog2(KEYWORD_CHARS);

  slt_pkg::mode_e         mode_q, mode_d;
  logic                   interp_q, interp_d;
  logic [COUNT_BITS-1:0]  line_q, line_d, col_q, col_d;
  logic [COUNT_BITS-1:0]  tline_q, tline_d, tcol_q, tcol_d, len_q, len_d;
  logic [5:0]             held_q, held_d;
  logic [7:0]             kbuf_q [KEYWORD_CHARS];
  logic                   kw_we;
  logic [IdxW-1:0]        kw_addr;
  logic [79:0]            kw_text;
  logic [5:0]             id_kind;

  function automatic logic [COUNT_BITS-1:0] inc(logic [COUNT_BITS-1:0] v);
    return (v == CMax) ? v : v + COne;
  endfunction

  function automatic logic [15:0] clip(logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS+16:0] w;
    w = (COUNT_BITS+17)'(v);
    return (w > (COUNT_BITS+17)'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  always_comb begin
    kw_text = '0;
    for (int j = 0; j < 10; j++) kw_text[8*j +: 8] = kbuf_q[j];
  end

  always_comb begin
    if (len_q > COUNT_BITS'(10) || len_q > COUNT_BITS'(KEYWORD_CHARS)) id_kind = slt_pkg::KIdent;
    else id_kind = slt_pkg::kw_kind(kw_text, len_q[3:0]);
  end

  always_comb begin
    logic [7:0]            c;
    logic                  rescan, found;
    logic [1:0]            n;
    logic [COUNT_BITS:0]   dsum;
    slt_pkg::out_beat_t    t;
    c = beat_i.ch;
    mode_d = mode_q; interp_d = interp_q; line_d = line_q; col_d = col_q;
    tline_d = tline_q; tcol_d = tcol_q; len_d = len_q; held_d = held_q;
    kw_we = 1'b0; kw_addr = '0;
    n = '0; rescan = 1'b0; found = 1'b0;
    dsum = {1'b0, tcol_q} + {1'b0, len_q};
    for (int i = 0; i < 3; i++) tok_o[i] = '0;
    t = '{token_kind: '0, error_kind: '0, start_line: clip(tline_q),
          start_column: clip(tcol_q), token_length: clip(len_q), last: 1'b0};

    if (beat_i.end_of_source) begin
      unique case (mode_q)
        slt_pkg::ModeIdent: begin t.token_kind = id_kind; tok_o[0] = t; n = 2'd1; end
        slt_pkg::ModeNumber, slt_pkg::ModeFraction: begin
          t.token_kind = slt_pkg::KNumber; tok_o[0] = t; n = 2'd1;
        end
        slt_pkg::ModeNumDot: begin
          t.token_kind = slt_pkg::KNumber; tok_o[0] = t;
          t.token_kind = slt_pkg::KDot; t.token_length = 16'd1;
          t.start_column = clip(dsum[COUNT_BITS] ? CMax : dsum[COUNT_BITS-1:0]);
          tok_o[1] = t; n = 2'd2;
        end
        slt_pkg::ModeOp2: begin t.token_kind = held_q; tok_o[0] = t; n = 2'd1; end
        slt_pkg::ModeSlash: begin t.token_kind = slt_pkg::KSlash; tok_o[0] = t; n = 2'd1; end
        slt_pkg::ModeString: begin
          t.token_kind = slt_pkg::KError; t.error_kind = slt_pkg::ErrString;
          tok_o[0] = t; n = 2'd1;
        end
        slt_pkg::ModeDollar: begin
          t.token_kind = slt_pkg::KError; t.error_kind = slt_pkg::ErrInterp;
          tok_o[0] = t; n = 2'd1;
        end
        default: ;
      endcase
      tok_o[n] = '{token_kind: slt_pkg::KEnd, error_kind: slt_pkg::ErrNone,
                   start_line: clip(line_q), start_column: clip(col_q),
                   token_length: 16'd0, last: 1'b0};
      n = n + 2'd1;
      mode_d = slt_pkg::ModeIdle; interp_d = 1'b0; line_d = COne; col_d = COne;
      tline_d = COne; tcol_d = COne; len_d = '0; held_d = '0;
    end else begin
      unique case (mode_q)
        slt_pkg::ModeIdent: begin
          if (slt_pkg::is_alpha(c) || slt_pkg::is_digit(c)) begin
            if (len_q < COUNT_BITS'(KEYWORD_CHARS)) begin
              kw_we = 1'b1; kw_addr = len_q[IdxW-1:0];
            end
            len_d = inc(len_q); col_d = inc(col_q);
          end else begin
            t.token_kind = id_kind; tok_o[0] = t; n = 2'd1; rescan = 1'b1;
          end
        end
        slt_pkg::ModeNumber: begin
          if (slt_pkg::is_digit(c)) begin len_d = inc(len_q); col_d = inc(col_q); end
          else if (c == ".") begin col_d = inc(col_q); mode_d = slt_pkg::ModeNumDot; end
          else begin t.token_kind = slt_pkg::KNumber; tok_o[0] = t; n = 2'd1; rescan = 1'b1; end
        end
        slt_pkg::ModeNumDot: begin
          if (slt_pkg::is_digit(c)) begin
            len_d = inc(inc(len_q)); col_d = inc(col_q); mode_d = slt_pkg::ModeFraction;
          end else begin
            t.token_kind = slt_pkg::KNumber; tok_o[0] = t;
            t.token_kind = slt_pkg::KDot; t.token_length = 16'd1;
            t.start_column = clip(dsum[COUNT_BITS] ? CMax : dsum[COUNT_BITS-1:0]);
            tok_o[1] = t; n = 2'd2; rescan = 1'b1;
          end
        end
        slt_pkg::ModeFraction: begin
          if (slt_pkg::is_digit(c)) begin len_d = inc(len_q); col_d = inc(col_q); end
          else begin t.token_kind = slt_pkg::KNumber; tok_o[0] = t; n = 2'd1; rescan = 1'b1; end
        end
        slt_pkg::ModeOp2: begin
          if (c == "=") begin
            t.token_kind = held_q + 6'd1; t.token_length = clip(inc(len_q));
            tok_o[0] = t; n = 2'd1;
            len_d = inc(len_q); col_d = inc(col_q); mode_d = slt_pkg::ModeIdle;
          end else begin
            t.token_kind = held_q; tok_o[0] = t; n = 2'd1; rescan = 1'b1;
          end
        end
        slt_pkg::ModeSlash: begin
          if (c == "/") begin col_d = inc(col_q); mode_d = slt_pkg::ModeComment; end
          else begin t.token_kind = slt_pkg::KSlash; tok_o[0] = t; n = 2'd1; rescan = 1'b1; end
        end
        slt_pkg::ModeComment: begin
          if (c == 8'h0A) begin
            line_d = inc(line_q); col_d = COne; mode_d = slt_pkg::ModeIdle;
          end else col_d = inc(col_q);
        end
        slt_pkg::ModeString: begin
          len_d = inc(len_q); col_d = inc(col_q);
          if (c == 8'h22) begin
            t.token_kind = slt_pkg::KString; t.token_length = clip(inc(len_q));
            tok_o[0] = t; n = 2'd1; mode_d = slt_pkg::ModeIdle;
          end else if (c == "$") mode_d = slt_pkg::ModeDollar;
          else if (c == 8'h0A) line_d = inc(line_q);
        end
        slt_pkg::ModeDollar: begin
          if (c == "{") begin
            t.token_kind = slt_pkg::KInterp; t.token_length = clip(inc(len_q));
            tok_o[0] = t; n = 2'd1;
            len_d = inc(len_q); col_d = inc(col_q); interp_d = 1'b1;
            mode_d = slt_pkg::ModeIdle;
          end else begin
            t.token_kind = slt_pkg::KError; t.error_kind = slt_pkg::ErrInterp;
            tok_o[0] = t; n = 2'd1; rescan = 1'b1;
          end
        end
        default: rescan = 1'b1;
      endcase

      // Fresh scan of the byte: column continues from col_q since flushes leave it.
      if (rescan) begin
        mode_d = slt_pkg::ModeIdle;
        if (c == " " || c == 8'h0D || c == 8'h09) col_d = inc(col_q);
        else if (c == 8'h0A) begin line_d = inc(line_q); col_d = COne; end
        else begin
          tline_d = line_q; tcol_d = col_q; len_d = COne; col_d = inc(col_q);
          t = '{token_kind: slt_pkg::KError, error_kind: slt_pkg::ErrNone,
                start_line: clip(line_q), start_column: clip(col_q),
                token_length: clip(COne), last: 1'b0};
          if (slt_pkg::is_alpha(c)) begin
            kw_we = 1'b1; kw_addr = '0; mode_d = slt_pkg::ModeIdent;
          end else if (slt_pkg::is_digit(c)) mode_d = slt_pkg::ModeNumber;
          else begin
            found = 1'b1;
            case (c)
              "/": mode_d = slt_pkg::ModeSlash;
              "!": begin held_d = slt_pkg::KBang; mode_d = slt_pkg::ModeOp2; end
              "=": begin held_d = slt_pkg::KEqual; mode_d = slt_pkg::ModeOp2; end
              "<": begin held_d = slt_pkg::KLess; mode_d = slt_pkg::ModeOp2; end
              ">": begin held_d = slt_pkg::KGreater; mode_d = slt_pkg::ModeOp2; end
              8'h22: mode_d = slt_pkg::ModeString;
              "}": begin
                if (interp_q) begin interp_d = 1'b0; mode_d = slt_pkg::ModeString; end
                else t.token_kind = slt_pkg::KRbrace;
              end
              "(": t.token_kind = slt_pkg::KLparen;
              ")": t.token_kind = slt_pkg::KRparen;
              "[": t.token_kind = slt_pkg::KLbrack;
              "]": t.token_kind = slt_pkg::KRbrack;
              "{": t.token_kind = slt_pkg::KLbrace;
              ";": t.token_kind = slt_pkg::KSemi;
              ",": t.token_kind = slt_pkg::KComma;
              ".": t.token_kind = slt_pkg::KDot;
              "-": t.token_kind = slt_pkg::KMinus;
              "+": t.token_kind = slt_pkg::KPlus;
              "*": t.token_kind = slt_pkg::KStar;
              default: t.error_kind = slt_pkg::ErrChar;
            endcase
            if (mode_d == slt_pkg::ModeIdle) begin
              tok_o[n] = t; n = n + 2'd1;
            end
          end
        end
      end
    end
    if (n != 2'd0) tok_o[n - 2'd1].last = 1'b1;
    count_o = n;
    if (!step_i) count_o = '0;
    if (found && !step_i) count_o = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= slt_pkg::ModeIdle;
      interp_q <= 1'b0;
      line_q <= COne; col_q <= COne; tline_q <= COne; tcol_q <= COne;
      len_q <= '0; held_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d; interp_q <= interp_d;
      line_q <= line_d; col_q <= col_d; tline_q <= tline_d; tcol_q <= tcol_d;
      len_q <= len_d; held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && kw_we) kbuf_q[kw_addr] <= beat_i.ch;
  end

endmodule

FILE: rtl/script_language_tokenizer.sv
// ----------------------------------------------------------------------------
// Script language tokenizer
// Streaming maximal-munch lexer: one source byte per beat, tokens out.
// ----------------------------------------------------------------------------
// Takes one byte (or end marker) per cycle, while the input is ready, into an
// input register; the scan logic then forms all tokens that the byte closes
// (at most three) in one pass and loads them into a small output queue. The
// queue drains one token per cycle while out_ready_i is high; a held byte is
// scanned only once the queue is empty or its last token leaves, so a byte that
// closes two or three tokens holds the input side. The output side is fully registered.
module script_language_tokenizer #(
  parameter int unsigned KEYWORD_CHARS = slt_pkg::KeywordChars,
  parameter int unsigned COUNT_BITS    = slt_pkg::CountBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  slt_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output slt_pkg::out_beat_t out_data_o
);
  logic               full_q, full_d;
  slt_pkg::in_beat_t  in_q;
  slt_pkg::out_beat_t tok [3];
  slt_pkg::out_beat_t q_q [3];
  logic [1:0]         cnt_q, cnt_d, ntok;
  logic               step, pop;

  slt_core #(.KEYWORD_CHARS(KEYWORD_CHARS), .COUNT_BITS(COUNT_BITS)) u_core (
    .clk_i, .rst_ni, .step_i(step), .beat_i(in_q), .tok_o(tok), .count_o(ntok)
  );

  assign pop = (cnt_q != 2'd0) && out_ready_i;
  // Process the held byte once the queue holds at most one token that leaves now.
  assign step = full_q && (cnt_q == 2'd0 || (cnt_q == 2'd1 && out_ready_i));
  assign in_ready_o = !full_q || step;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o = q_q[0];

  always_comb begin
    full_d = full_q;
    if (step) full_d = 1'b0;
    if (in_valid_i && in_ready_o) full_d = 1'b1;
    cnt_d = step ? ntok : cnt_q - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (step) q_q <= tok;
    else if (pop) begin
      q_q[0] <= q_q[1]; q_q[1] <= q_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0; cnt_q <= '0;
    end else begin
      full_q <= full_d; cnt_q <= cnt_d;
    end
  end

  a_no_step_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> (cnt_q == 2'd0 || pop)) else $error("tokens overwritten");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3 || !full_q || !step) else $error("queue overflow");
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cnt_q == 2'd1) |-> out_data_o.last) else $error("last missing");
endmodule

FILE: bench/slt_checker.sv
// ----------------------------------------------------------------------------
// Tokenizer checker
// Watches both channels, predicts the token stream and compares each token.
// ----------------------------------------------------------------------------
module slt_checker
  import slt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_beat_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_beat_t out_data_i,
  output int        errors_o,
  output int        pending_o
);

  localparam int unsigned CntMax = (1 << CountBits) - 1;

  out_beat_t  tokens_q[$];
  mode_e      mode;
  logic       in_interp;
  int unsigned line_no, col_no, tok_line, tok_col, lex_len;
  logic [7:0] kw_buf [KeywordChars];
  logic [5:0] held_kind;
  out_beat_t  step_toks[$];

  assign pending_o = tokens_q.size();

  function automatic int unsigned inc(int unsigned v);
    return (v >= CntMax) ? CntMax : v + 1;
  endfunction

  function automatic logic [15:0] clip(int unsigned v);
    return (v > 16'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic bit alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic push_tok(logic [5:0] k, logic [1:0] e, int unsigned ln,
                          int unsigned cl, int unsigned len);
    out_beat_t t;
    t.token_kind = k;
    t.error_kind = e;
    t.start_line = clip(ln);
    t.start_column = clip(cl);
    t.token_length = clip(len);
    t.last = 1'b0;
    step_toks.push_back(t);
  endtask

  task automatic push_cur(logic [5:0] k, logic [1:0] e);
    push_tok(k, e, tok_line, tok_col, lex_len);
  endtask

  function automatic logic [5:0] word_kind();
    string words [22];
    logic [5:0] k;
    bit ok;
    words = '{"and", "case", "class", "default", "else", "false", "for", "fun",
              "if", "in", "instanceof", "nil", "nmut", "or", "print", "return",
              "super", "switch", "this", "true", "var", "while"};
    k = KIdent;
    if (lex_len <= KeywordChars && lex_len <= 10) begin
      for (int i = 0; i < 22; i++) begin
        ok = (words[i].len() == lex_len);
        for (int j = 0; j < words[i].len() && ok; j++)
          if (words[i][j] != kw_buf[j]) ok = 0;
        if (ok && k == KIdent) k = KKw0 + 6'(i);
      end
    end
    return k;
  endfunction

  task automatic consume();
    lex_len = inc(lex_len);
    col_no = inc(col_no);
  endtask

  task automatic start_tok(logic [7:0] c);
    mode = ModeIdle;
    if (c == " " || c == 8'h0D || c == 8'h09) begin
      col_no = inc(col_no);
      return;
    end
    if (c == 8'h0A) begin
      line_no = inc(line_no);
      col_no = 1;
      return;
    end
    tok_line = line_no;
    tok_col = col_no;
    lex_len = 0;
    if (alpha(c)) begin
      kw_buf[0] = c;
      consume();
      mode = ModeIdent;
      return;
    end
    if (digit(c)) begin
      consume();
      mode = ModeNumber;
      return;
    end
    consume();
    case (c)
      "/": mode = ModeSlash;
      "!": begin held_kind = KBang; mode = ModeOp2; end
      "=": begin held_kind = KEqual; mode = ModeOp2; end
      "<": begin held_kind = KLess; mode = ModeOp2; end
      ">": begin held_kind = KGreater; mode = ModeOp2; end
      "\"": mode = ModeString;
      "}": begin
        if (in_interp) begin
          in_interp = 0;
          mode = ModeString;
        end else push_cur(KRbrace, ErrNone);
      end
      "(": push_cur(KLparen, ErrNone);
      ")": push_cur(KRparen, ErrNone);
      "[": push_cur(KLbrack, ErrNone);
      "]": push_cur(KRbrack, ErrNone);
      "{": push_cur(KLbrace, ErrNone);
      ";": push_cur(KSemi, ErrNone);
      ",": push_cur(KComma, ErrNone);
      ".": push_cur(KDot, ErrNone);
      "-": push_cur(KMinus, ErrNone);
      "+": push_cur(KPlus, ErrNone);
      "*": push_cur(KStar, ErrNone);
      default: push_cur(KError, ErrChar);
    endcase
  endtask

  task automatic dot_after_number();
    int unsigned dc;
    dc = tok_col + lex_len;
    push_cur(KNumber, ErrNone);
    push_tok(KDot, ErrNone, tok_line, (dc > CntMax) ? CntMax : dc, 1);
  endtask

  task automatic scan(logic [7:0] c);
    case (mode)
      ModeIdent: begin
        if (alpha(c) || digit(c)) begin
          if (lex_len < KeywordChars) kw_buf[lex_len] = c;
          consume();
        end else begin
          push_cur(word_kind(), ErrNone);
          start_tok(c);
        end
      end
      ModeNumber: begin
        if (digit(c)) consume();
        else if (c == ".") begin
          col_no = inc(col_no);
          mode = ModeNumDot;
        end else begin
          push_cur(KNumber, ErrNone);
          start_tok(c);
        end
      end
      ModeNumDot: begin
        if (digit(c)) begin
          lex_len = inc(lex_len);
          consume();
          mode = ModeFraction;
        end else begin
          dot_after_number();
          start_tok(c);
        end
      end
      ModeFraction: begin
        if (digit(c)) consume();
        else begin
          push_cur(KNumber, ErrNone);
          start_tok(c);
        end
      end
      ModeOp2: begin
        if (c == "=") begin
          consume();
          mode = ModeIdle;
          push_cur(held_kind + 6'd1, ErrNone);
        end else begin
          push_cur(held_kind, ErrNone);
          start_tok(c);
        end
      end
      ModeSlash: begin
        if (c == "/") begin
          col_no = inc(col_no);
          mode = ModeComment;
        end else begin
          push_cur(KSlash, ErrNone);
          start_tok(c);
        end
      end
      ModeComment: begin
        if (c == 8'h0A) begin
          line_no = inc(line_no);
          col_no = 1;
          mode = ModeIdle;
        end else col_no = inc(col_no);
      end
      ModeString: begin
        consume();
        if (c == "\"") begin
          mode = ModeIdle;
          push_cur(KString, ErrNone);
        end else if (c == "$") mode = ModeDollar;
        else if (c == 8'h0A) line_no = inc(line_no);
      end
      ModeDollar: begin
        if (c == "{") begin
          consume();
          in_interp = 1;
          mode = ModeIdle;
          push_cur(KInterp, ErrNone);
        end else begin
          push_cur(KError, ErrInterp);
          start_tok(c);
        end
      end
      default: start_tok(c);
    endcase
  endtask

  task automatic clear_state();
    mode = ModeIdle;
    in_interp = 0;
    line_no = 1;
    col_no = 1;
    tok_line = 1;
    tok_col = 1;
    lex_len = 0;
    held_kind = '0;
  endtask

  task automatic end_source();
    case (mode)
      ModeIdent: push_cur(word_kind(), ErrNone);
      ModeNumber, ModeFraction: push_cur(KNumber, ErrNone);
      ModeNumDot: dot_after_number();
      ModeOp2: push_cur(held_kind, ErrNone);
      ModeSlash: push_cur(KSlash, ErrNone);
      ModeString: push_cur(KError, ErrString);
      ModeDollar: push_cur(KError, ErrInterp);
      default: ;
    endcase
    push_tok(KEnd, ErrNone, line_no, col_no, 0);
    clear_state();
  endtask

  initial begin
    errors_o = 0;
    clear_state();
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni) begin
      // take the output beat first: a token predicted this edge cannot leave yet
      if (out_valid_i && out_ready_i) begin
        if (tokens_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected token, actual %p", $time, out_data_i);
        end else begin
          want = tokens_q.pop_front();
          if (want !== out_data_i) begin
            errors_o++;
            $display("%0t: token mismatch, expected %p, actual %p",
                     $time, want, out_data_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        step_toks.delete();
        if (in_data_i.end_of_source) end_source();
        else scan(in_data_i.ch);
        if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
        foreach (step_toks[i]) tokens_q.push_back(step_toks[i]);
      end
    end
  end

endmodule

FILE: bench/tb_script_language_tokenizer.sv
// ----------------------------------------------------------------------------
// Tokenizer testbench
// Drives source text, directed and random, with gaps and stalls; the checker
// predicts every token and the top gives the verdict.
// ----------------------------------------------------------------------------
module tb_script_language_tokenizer;
  import slt_pkg::*;

  localparam int Limit = 2000;

  logic      clk, rst_n;
  logic      in_valid, in_ready, out_valid, out_ready;
  in_beat_t  in_data;
  out_beat_t out_data;
  int        errors, pending, idle_cycles;
  bit        hold_off;

  script_language_tokenizer dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  slt_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .errors_o(errors), .pending_o(pending)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // send one byte, or the end marker; hold until the beat is taken
  task automatic send(logic [7:0] c, logic eos);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{ch: c, end_of_source: eos};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send(s[i], 1'b0);
  endtask

  function automatic string pick_fragment();
    string frags [24];
    frags = '{"and ", "case", "class ", "default", "else", "false", "for(",
              "fun ", "if", "in ", "instanceof", "nil", "nmut", "or ",
              "print ", "return;", "super", "switch", "this.x", "true ",
              "var a1 = ", "while", "instanceofx", "_Zz9 "};
    return frags[$urandom_range(0, 23)];
  endfunction

  task automatic random_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) send_text(pick_fragment());
    else if (r < 40) begin
      repeat ($urandom_range(1, 4)) send(8'("0" + $urandom_range(0, 9)), 1'b0);
      if ($urandom_range(0, 2) == 0) send_text(".5 ");
    end else if (r < 52) begin
      send("\"", 1'b0);
      repeat ($urandom_range(0, 4)) send(8'("a" + $urandom_range(0, 25)), 1'b0);
      if ($urandom_range(0, 1)) send_text("${x}y\"");
      else send("\"", 1'b0);
    end else if (r < 65) send_text(" \n\t\r");
    else if (r < 72) send_text("// note\n");
    else if (r < 88) begin
      string ops;
      ops = "()[]{};,.-+*/!=<>";
      send(ops[$urandom_range(0, ops.len()-1)], 1'b0);
      if ($urandom_range(0, 1)) send("=", 1'b0);
    end else send(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // long hold-off so the output queue fills and the input stalls
  initial begin
    hold_off = 1'b0;
    wait (rst_n);
    repeat (300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (60) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    int g;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) out_ready <= 1'b0;
      else if (g > 0) begin
        out_ready <= 1'b0;
        g--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) g = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= Limit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: operators, number forms, strings, errors, end handling
    send_text("!= == <= >= ! = < > (a)[b]{c};,.-+*/ // c\n");
    send_text("12. 3.25 7.x ");
    send_text("\"s$q\" \"a${b}c\" abcdefghijkl ");
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send("@", 1'b0);
    send("1", 1'b0);
    send(".", 1'b0);
    send(8'h00, 1'b1);
    send_text("\"open");
    send(8'h00, 1'b1);
    send_text("\"x$");
    send(8'hFF, 1'b1);
    send(8'h00, 1'b1);
    for (int i = 0; i < 36; i++) begin
      random_token();
      if ($urandom_range(0, 20) == 0) send(8'($urandom_range(0, 255)), 1'b1);
    end
    send(8'h00, 1'b1);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
